FILE: rtl/slid_pkg.sv
`default_nettype none

package slid_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain in the cycle of a transfer.
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/slid_cell.sv
`default_nettype none

module slid_cell (
    input  wire logic                              aclk,
    input  wire slid_pkg::cell_cmd_t               cmd,
    input  wire logic                              valid,
    input  wire logic                              last,
    input  wire logic                              prev_lt,
    input  wire logic signed [slid_pkg::VALUE_W-1:0] prev_value,
    input  wire logic signed [slid_pkg::VALUE_W-1:0] next_value,
    output logic                                   lt,
    output logic                                   eq,
    output logic signed [slid_pkg::VALUE_W-1:0]    value,
    output logic        [slid_pkg::VALUE_W-1:0]    tail_value
);
    import slid_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    assign lt         = valid && (entry_reg < cmd.value);
    assign eq         = valid && (entry_reg == cmd.value);
    assign value      = entry_reg;
    assign tail_value = last ? entry_reg : '0;

    // Entries below the operand stay put; the rest shift one place.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins && !lt) begin
            entry_next = prev_lt ? cmd.value : prev_value;
        end else if (cmd.del && !lt) begin
            entry_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sorted_list_insert_delete.sv
`default_nettype none

// Channel | Direction | Handshake        | Payload
// s_      | in        | s_tvalid/tready  | tuser: kind; tdata: value
// m_      | out       | m_tvalid/tready  | tuser: status; tdata: count, smallest, largest
//
// In the cycle of the input transfer every cell of the compare-and-shift chain
// updates at once, and in the next cycle the result register is loaded from the
// chain. No new input is taken while a result is being built, and one is taken only
// while the result register is empty or draining.
// Reset (aresetn low, synchronous) empties the store and drops any pending result;
// the cell contents are not cleared since only the first entry_count cells are read.
// A stalled m_ side holds the result and keeps s_tready low.
module sorted_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [31:0] value
    input  wire logic        s_tuser,  // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,  // [4:0] entry_count, [36:5] smallest, [68:37] largest
    output logic [1:0]       m_tuser   // [1:0] status
);
    import slid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             calc_reg;
    logic             out_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [71:0]      out_data_reg;
    status_t          out_status_reg;

    logic             s_acc;
    logic             full;
    logic             found;
    cell_cmd_t        cmd;
    logic signed [VALUE_W-1:0] in_value;

    logic [CAPACITY-1:0]               cell_valid;
    logic [CAPACITY-1:0]               cell_last;
    logic [CAPACITY-1:0]               cell_lt;
    logic [CAPACITY-1:0]               cell_eq;
    logic signed [VALUE_W-1:0]         cell_value [CAPACITY];
    logic [VALUE_W-1:0]                cell_tail  [CAPACITY];
    logic [VALUE_W-1:0]                largest;
    logic [VALUE_W-1:0]                smallest;
    logic [CNT_W+COUNT_W-1:0]          count_ext;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = !calc_reg && (!out_valid_reg || m_tready);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign found    = |cell_eq;

    // The input tdata carries the whole 32-bit operand.
    assign in_value = s_tdata;

    always_comb begin
        cmd.value = in_value;
        cmd.ins   = s_acc && (kind_t'(s_tuser) == KIND_INSERT) && !full;
        cmd.del   = s_acc && (kind_t'(s_tuser) == KIND_DELETE) && found;
    end

    // A cell is occupied when its position is below the entry count; the last
    // occupied cell drives the largest value onto the OR tree.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_valid[i] = (CNT_W'(i) < count_reg);
        end
        for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_last[i] = cell_valid[i] && !cell_valid[i+1];
        end
        cell_last[CAPACITY-1] = cell_valid[CAPACITY-1];
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                      prev_lt_w;
            logic signed [VALUE_W-1:0] prev_value_w;
            logic signed [VALUE_W-1:0] next_value_w;

            if (g == 0) begin : g_first
                assign prev_lt_w    = 1'b1;
                assign prev_value_w = cmd.value;
            end else begin : g_mid
                assign prev_lt_w    = cell_lt[g-1];
                assign prev_value_w = cell_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_end
                assign next_value_w = cell_value[g];
            end else begin : g_inner
                assign next_value_w = cell_value[g+1];
            end

            slid_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .valid      (cell_valid[g]),
                .last       (cell_last[g]),
                .prev_lt    (prev_lt_w),
                .prev_value (prev_value_w),
                .next_value (next_value_w),
                .lt         (cell_lt[g]),
                .eq         (cell_eq[g]),
                .value      (cell_value[g]),
                .tail_value (cell_tail[g])
            );
        end
    endgenerate

    // At most one cell is last, so the largest value is a plain OR over the chain.
    always_comb begin
        largest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            largest = largest | cell_tail[i];
        end
        smallest  = (count_reg == '0) ? '0 : cell_value[0];
        count_ext = {{COUNT_W{1'b0}}, count_reg};
    end

    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        if (s_acc) begin
            status_next = STATUS_DONE;
            if (kind_t'(s_tuser) == KIND_INSERT) begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else begin
                if (!found) begin
                    status_next = STATUS_NOT_FOUND;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            calc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            calc_reg  <= s_acc;
            if (calc_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (calc_reg) begin
            out_status_reg <= status_reg;
            out_data_reg   <= {3'b000, largest, smallest, count_ext[COUNT_W-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_calc_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> calc_reg && !s_tready)
        else $error("result build did not follow an input transfer");

    a_calc_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        calc_reg |-> !m_tvalid)
        else $error("result register busy while a result is built");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && full && (kind_t'(s_tuser) == KIND_INSERT)) |=> $stable(count_reg))
        else $error("refused insert changed the entry count");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/sorted_list_checker.sv
`timescale 1ns / 100ps

module sorted_list_checker #(
    parameter int CAPACITY = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [slid_pkg::VALUE_W-1:0]  s_tdata,  // [31:0] value
    input  wire logic                          s_tuser,  // [0] kind
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [71:0]                   m_tdata,  // [4:0] entry_count, [36:5] smallest, [68:37] largest
    input  wire logic [slid_pkg::STATUS_W-1:0] m_tuser,  // [1:0] status
    output int                                 fail_count,
    output int                                 pending_results
);
    import slid_pkg::*;

    typedef struct {
        status_t                   status;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] smallest;
        logic signed [VALUE_W-1:0] largest;
    } list_summary_t;

    logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
    int                        shadow_count = 0;
    int                        mismatch_total = 0;
    list_summary_t             expected_summaries [$];

    // Applies one operation to the shadow list and queues the summary it produces.
    task automatic apply_list_op(input kind_t op, input logic signed [VALUE_W-1:0] operand);
        list_summary_t summary;
        int            pos;
        int            k;
        summary.status = STATUS_DONE;
        pos = 0;
        if (op == KIND_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                summary.status = STATUS_FULL;
            end else begin
                while (pos < shadow_count && shadow_entries[pos] < operand) pos++;
                for (k = shadow_count; k > pos; k--) shadow_entries[k] = shadow_entries[k - 1];
                shadow_entries[pos] = operand;
                shadow_count++;
            end
        end else begin
            while (pos < shadow_count && shadow_entries[pos] != operand) pos++;
            if (pos >= shadow_count) begin
                summary.status = STATUS_NOT_FOUND;
            end else begin
                for (k = pos; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k + 1];
                shadow_count--;
            end
        end
        summary.entry_count = COUNT_W'(shadow_count);
        if (shadow_count == 0) begin
            summary.smallest = '0;
            summary.largest  = '0;
        end else begin
            summary.smallest = shadow_entries[0];
            summary.largest  = shadow_entries[shadow_count - 1];
        end
        expected_summaries.push_back(summary);
    endtask

    task automatic check_field(input string field, input longint expected, input longint actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin
        list_summary_t oldest;
        if (!aresetn) begin
            shadow_count = 0;
            expected_summaries.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                apply_list_op(kind_t'(s_tuser), s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_summaries.size() == 0) begin
                    $error("result transfer with no operation waiting for it");
                    mismatch_total++;
                end else begin
                    oldest = expected_summaries.pop_front();
                    check_field("status", longint'(oldest.status), longint'(m_tuser));
                    check_field("entry_count", longint'(oldest.entry_count),
                                longint'(m_tdata[4:0]));
                    check_field("smallest", longint'(oldest.smallest),
                                longint'($signed(m_tdata[36:5])));
                    check_field("largest", longint'(oldest.largest),
                                longint'($signed(m_tdata[68:37])));
                end
            end
        end
        fail_count      <= mismatch_total;
        pending_results <= expected_summaries.size();
    end

endmodule

FILE: tb/sv/tb_sorted_list_insert_delete.sv
`timescale 1ns / 100ps

module tb_sorted_list_insert_delete;
    import slid_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int RANDOM_OPS       = 1900;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 10;
    localparam int POOL_DEPTH       = 24;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    // Ways the result side can pace itself between long hold-offs.
    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_SLOW,
        SINK_PERIODIC
    } sink_mode_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;    // [31:0] value
    logic                 s_tuser  = 1'b0;  // [0] kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [71:0]          m_tdata;          // [4:0] entry_count, [36:5] smallest, [68:37] largest
    logic [STATUS_W-1:0]  m_tuser;          // [1:0] status

    int fail_count;
    int pending_results;

    // Values that were recently offered for insertion. Deletes draw on them so that
    // most deletes find a match, while stale entries still give not-found results.
    logic [VALUE_W-1:0] operand_pool [$];

    // Transfers left in the current sender burst.
    int burst_left = 0;

    sorted_list_insert_delete #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The checker watches both channels, keeps its own sorted list and compares
    // every result transfer with the summary it predicted.
    sorted_list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offers one operation and returns at the edge where the transfer takes place.
    // The ready sampled right after the edge is the value the block showed at that edge.
    task automatic offer_op(input kind_t op, input logic [VALUE_W-1:0] operand);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= operand;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Sends one operation and then applies the burst and gap pacing of the sender.
    // Valid is lowered only when a gap follows, so it never toggles within one step.
    task automatic issue_op(input kind_t op, input logic [VALUE_W-1:0] operand);
        int gap;
        offer_op(op, operand);
        if (op == KIND_INSERT) begin
            operand_pool.push_back(operand);
            if (operand_pool.size() > POOL_DEPTH) void'(operand_pool.pop_front());
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            // Roughly a third of the bursts run straight into the next one.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Chooses an operand. Small values and the pool give many duplicates and matches,
    // the extremes exercise signed ordering, and full-width values toggle every bit.
    function automatic logic [VALUE_W-1:0] pick_operand(input kind_t op);
        logic signed [VALUE_W-1:0] extremes [6];
        int                        sel;
        extremes = '{VALUE_MIN, VALUE_MAX, 32'sd0, -32'sd1, VALUE_MIN + 1, VALUE_MAX - 1};
        sel = $urandom_range(0, 9);
        if (op == KIND_DELETE && operand_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
            return operand_pool[$urandom_range(0, operand_pool.size() - 1)];
        end
        if (sel < 3) begin
            return int'($urandom_range(0, 8)) - 4;
        end else if (sel == 3) begin
            return extremes[$urandom_range(0, 5)];
        end else if (sel < 6 && operand_pool.size() != 0) begin
            return operand_pool[$urandom_range(0, operand_pool.size() - 1)];
        end
        return $urandom();
    endfunction

    // Stimulus: a directed opening, then random phases that lean toward inserts or
    // toward deletes so that the list keeps swinging between empty and full.
    initial begin : stimulus
        int   i;
        int   phase_left;
        int   insert_pct;
        kind_t op;
        phase_left = 0;
        insert_pct = 50;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Delete on an empty list, then a delete that misses a lone entry.
        issue_op(KIND_DELETE, 32'd0);
        issue_op(KIND_INSERT, 32'd0);
        issue_op(KIND_DELETE, 32'd5);
        issue_op(KIND_DELETE, 32'd0);
        // Signed extremes and equal values; the delete of 1 takes the first of the pair.
        issue_op(KIND_INSERT, VALUE_MAX);
        issue_op(KIND_INSERT, VALUE_MIN);
        issue_op(KIND_INSERT, -32'sd1);
        issue_op(KIND_INSERT, 32'sd1);
        issue_op(KIND_INSERT, 32'sd1);
        issue_op(KIND_DELETE, 32'sd1);
        issue_op(KIND_DELETE, VALUE_MAX);
        issue_op(KIND_DELETE, VALUE_MIN);
        // Fill the list up to its capacity, with a few repeated values among the entries.
        for (i = 0; i < CAPACITY - 2; i++) begin
            issue_op(KIND_INSERT, (i % 4 == 0) ? -32'sd1 : (i * 1000 - 7000));
        end
        // A full list refuses an insert; a miss and a hit on a full list follow.
        issue_op(KIND_INSERT, 32'sd42);
        issue_op(KIND_DELETE, 32'sd12345);
        issue_op(KIND_DELETE, 32'sd1);

        for (i = 0; i < RANDOM_OPS; i++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(30, 90);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            phase_left--;
            op = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
            issue_op(op, pick_operand(op));
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        // Wait for every predicted result to arrive, then give the block a few more
        // cycles so that a stray result would still be caught.
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result side: the pacing mode is redrawn whenever the current one runs out, and twice
    // the sink holds off for a long stretch so that the block fills up and stalls its input.
    initial begin : result_sink
        int         cycle_index;
        int         mode_left;
        int         hold_left;
        sink_mode_t sink_mode;
        cycle_index = 0;
        mode_left   = 0;
        hold_left   = 0;
        sink_mode   = SINK_ALWAYS;
        forever begin
            @(posedge aclk);
            cycle_index++;
            if (cycle_index == 600 || cycle_index == 3000) hold_left = LONG_HOLD_CYCLES;
            if (mode_left == 0) begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_ALWAYS: m_tready <= 1'b1;
                    SINK_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                    SINK_SLOW:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= (cycle_index % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/slid_pkg.sv
rtl/slid_cell.sv
rtl/sorted_list_insert_delete.sv
tb/sv/sorted_list_checker.sv
tb/sv/tb_sorted_list_insert_delete.sv
